/* sv/qspd_pkg.sv */
`default_nettype none

package qspd_pkg;

	localparam int MAX_PAIRS       = 16;
	localparam int KEY_MAX_BYTES   = 255;
	localparam int VALUE_MAX_BYTES = 1023;

	localparam int TOK_MAX   = (KEY_MAX_BYTES > VALUE_MAX_BYTES) ? KEY_MAX_BYTES : VALUE_MAX_BYTES;
	localparam int LEN_W     = $clog2(TOK_MAX + 1);
	localparam int PAIR_W    = 5;
	localparam int LIMIT_W   = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	// An input byte causes at most this many results.
	localparam int RES_MAX   = 5;
	localparam int RES_IDX_W = $clog2(RES_MAX);
	localparam int CNT_W     = $clog2(RES_MAX + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_KEY       = 2'd0,
		KIND_VALUE     = 2'd1,
		KIND_PAIR_END  = 2'd2,
		KIND_QUERY_END = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]        data;
		kind_t             kind;
		logic [PAIR_W-1:0] pn;
	} res_t;

	typedef struct packed {
		res_t [RES_MAX-1:0] res;
		logic [CNT_W-1:0]   cnt;
	} bundle_t;

endpackage

`default_nettype wire

/* sv/qspd_front.sv */
`default_nettype none

module qspd_front
	import qspd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic               cfg_valid,
	input  wire logic [LIMIT_W-1:0] pair_cap,
	input  wire logic               q_full,
	output logic                    q_push,
	output bundle_t                 q_data
);

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [1:0]        pc;
		logic [7:0]        dig;
		logic [LEN_W-1:0]  len;
		logic              cut;
		logic [PAIR_W-1:0] pcnt;
		bundle_t           out;
	} work_t;

	phase_t              phase_q;
	logic [1:0]          pend_cnt_q;
	logic [7:0]          pend_dig_q;
	logic [LEN_W-1:0]    tok_len_q;
	logic                tok_cut_q;
	logic [PAIR_W-1:0]   pair_cnt_q;
	logic [LIMIT_W-1:0]  pair_cap_q;
	work_t               w_d;
	logic                accept;
	logic                at_limit;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic work_t put(work_t w, logic [7:0] b, kind_t k);
		if (w.out.cnt < CNT_W'(RES_MAX)) begin
			w.out.res[w.out.cnt[RES_IDX_W-1:0]] = '{data: b, kind: k, pn: w.pcnt};
			w.out.cnt = w.out.cnt + CNT_W'(1);
		end
		return w;
	endfunction

	function automatic work_t emit(work_t w, logic [7:0] c);
		logic [LEN_W-1:0] lim;
		lim = (w.phase == PH_KEY) ? LEN_W'(KEY_MAX_BYTES) : LEN_W'(VALUE_MAX_BYTES);
		if (!w.cut) begin
			if (c == CH_NUL || w.len >= lim) begin
				w.cut = 1'b1;
			end else begin
				w = put(w, c, (w.phase == PH_KEY) ? KIND_KEY : KIND_VALUE);
				w.len = w.len + LEN_W'(1);
			end
		end
		return w;
	endfunction

	// Held escape bytes leave as literal text.
	function automatic work_t flush(work_t w);
		if (w.pc != 2'd0) begin
			w = emit(w, CH_PERCENT);
		end
		if (w.pc == 2'd2) begin
			w = emit(w, w.dig);
		end
		w.pc = 2'd0;
		return w;
	endfunction

	function automatic work_t token_byte(work_t w, logic [7:0] c);
		if (w.pc == 2'd1) begin
			if (is_hex(c)) begin
				w.dig = c;
				w.pc = 2'd2;
				return w;
			end
			w = flush(w);
		end else if (w.pc == 2'd2) begin
			if (is_hex(w.dig) && is_hex(c)) begin
				w.pc = 2'd0;
				return emit(w, {hex_val(w.dig), hex_val(c)});
			end
			w = flush(w);
		end
		if (c == CH_PERCENT) begin
			w.pc = 2'd1;
		end else if (c == CH_PLUS) begin
			w = emit(w, CH_SPACE);
		end else begin
			w = emit(w, c);
		end
		return w;
	endfunction

	function automatic work_t start_token(work_t w, phase_t ph);
		w.phase = ph;
		w.len = '0;
		w.cut = 1'b0;
		w.pc = 2'd0;
		return w;
	endfunction

	function automatic work_t close_pair(work_t w);
		w = flush(w);
		w = put(w, 8'h00, KIND_PAIR_END);
		w.pcnt = w.pcnt + PAIR_W'(1);
		return w;
	endfunction

	assign at_limit = (pair_cnt_q >= PAIR_W'(pair_cap_q)) || (int'(pair_cnt_q) >= MAX_PAIRS);

	always_comb begin
		w_d.phase = phase_q;
		w_d.pc = pend_cnt_q;
		w_d.dig = pend_dig_q;
		w_d.len = tok_len_q;
		w_d.cut = tok_cut_q;
		w_d.pcnt = pair_cnt_q;
		w_d.out = '0;
		unique case (phase_q)
			PH_START: begin
				if (data_byte == CH_NUL || data_byte == CH_AMP || data_byte == CH_EQUALS ||
					at_limit) begin
					w_d.phase = PH_STOP;
				end else begin
					w_d = start_token(w_d, PH_KEY);
					w_d = token_byte(w_d, data_byte);
				end
			end
			PH_KEY, PH_VALUE: begin
				if (data_byte == CH_NUL) begin
					w_d = close_pair(w_d);
					w_d.phase = PH_STOP;
				end else if (data_byte == CH_AMP) begin
					w_d = close_pair(w_d);
					w_d.phase = PH_START;
				end else if (data_byte == CH_EQUALS && phase_q == PH_KEY) begin
					w_d = flush(w_d);
					w_d = start_token(w_d, PH_VALUE);
				end else begin
					w_d = token_byte(w_d, data_byte);
				end
			end
			default: begin
				w_d.phase = PH_STOP;
			end
		endcase
		if (last_byte) begin
			if (w_d.phase == PH_KEY || w_d.phase == PH_VALUE) begin
				w_d = close_pair(w_d);
			end
			w_d = put(w_d, 8'h00, KIND_QUERY_END);
			w_d.phase = PH_START;
			w_d.pc = 2'd0;
			w_d.dig = 8'h00;
			w_d.len = '0;
			w_d.cut = 1'b0;
			w_d.pcnt = '0;
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (w_d.out.cnt != '0);
	assign q_data   = w_d.out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			pend_cnt_q  <= 2'd0;
			pend_dig_q  <= 8'h00;
			tok_len_q   <= '0;
			tok_cut_q   <= 1'b0;
			pair_cnt_q  <= '0;
			pair_cap_q  <= LIMIT_RESET;
		end else begin
			if (cfg_valid) begin
				pair_cap_q <= pair_cap;
			end
			if (accept) begin
				phase_q    <= w_d.phase;
				pend_cnt_q <= w_d.pc;
				pend_dig_q <= w_d.dig;
				tok_len_q  <= w_d.len;
				tok_cut_q  <= w_d.cut;
				pair_cnt_q <= w_d.pcnt;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/qspd_queue.sv */
`default_nettype none

module qspd_queue
	import qspd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	output logic         full,
	input  wire logic    pop,
	output bundle_t      head,
	output logic         empty
);

	bundle_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/qspd_back.sv */
`default_nettype none

module qspd_back
	import qspd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bundle_t     head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [1:0]       kind,
	output logic [PAIR_W-1:0] pair_number,
	output logic             last_result
);

	logic [RES_IDX_W-1:0] idx_q;
	logic                 accept;
	res_t                 cur;

	assign cur         = head.res[idx_q];
	assign out_valid   = !empty;
	assign out_byte    = cur.data;
	assign kind        = cur.kind;
	assign pair_number = cur.pn;
	assign last_result = (CNT_W'(idx_q) + CNT_W'(1)) == head.cnt;
	assign accept      = out_valid && !out_stall;
	// The bundle leaves the queue once its final result is taken.
	assign pop         = accept && last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= last_result ? '0 : idx_q + RES_IDX_W'(1);
		end
	end

endmodule

`default_nettype wire

/* sv/query_string_percent_decoder.sv */
// Query string percent decoder.
// Input channel: in_valid / in_stall with data_byte and last_byte; one raw byte of
// the query string is accepted at each edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with out_byte, kind, pair_number and
// last_result; a result is taken at each edge where out_valid is high and out_stall low.
// Configuration: pair_cap is written at an edge where cfg_valid and cfg_ready are high;
// cfg_ready is always high. Write it only while no item is in flight.
// Path: the front decodes each accepted byte combinationally into a bundle of up to
// five results and pushes it into a four-entry queue of bundles; the back reads the
// queue head and sends one result per cycle while out_stall is low.
// Throughput: one byte per cycle while in_stall is low and bytes yield at most one
// result each. Bytes with no result push no bundle into the queue.
// Reset: the queue is emptied, the parser returns to key start with no pairs counted,
// and pair_cap returns to 16.
// Stall: a stalled result holds on the outputs; once the queue holds four bundles,
// in_stall rises until a bundle drains.
`default_nettype none

module query_string_percent_decoder
	import qspd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [LIMIT_W-1:0] pair_cap,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic [1:0]              kind,
	output logic [PAIR_W-1:0]       pair_number,
	output logic                    last_result
);

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_empty;
	bundle_t q_wdata;
	bundle_t q_head;

	assign cfg_ready = 1'b1;

	qspd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.pair_cap  (pair_cap),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	qspd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	qspd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.kind        (kind),
		.pair_number (pair_number),
		.last_result (last_result)
	);

endmodule

`default_nettype wire

/* tb/sv/query_decode_checker.sv */
`timescale 1ns / 1ps

module query_decode_checker
	import qspd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [LIMIT_W-1:0] pair_cap,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [7:0]         out_byte,
	input  wire logic [1:0]         kind,
	input  wire logic [PAIR_W-1:0]  pair_number,
	input  wire logic               last_result,
	output int                      mismatches,
	output int                      outstanding,
	output int                      results_checked
);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;

	localparam logic [1:0] ESC_NONE    = 2'd0;
	localparam logic [1:0] ESC_PERCENT = 2'd1;
	localparam logic [1:0] ESC_DIGIT   = 2'd2;

	typedef enum logic [1:0] {
		AT_KEY_START = 2'd0,
		IN_KEY       = 2'd1,
		IN_VALUE     = 2'd2,
		STOPPED      = 2'd3
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]        data;
		kind_t             kind;
		logic [PAIR_W-1:0] pn;
		logic              last;
	} decoded_t;

	parse_phase_t       phase;
	logic [1:0]         esc_held;
	logic [7:0]         esc_digit;
	int unsigned        tok_len;
	logic               tok_cut;
	logic [PAIR_W-1:0]  pairs_closed;
	logic [LIMIT_W-1:0] pair_limit;
	decoded_t           byte_results[$];
	decoded_t           decoded_queue[$];

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] nibble(input logic [7:0] c);
		if (c <= "9")
			return 4'(c - "0");
		else if (c >= "a")
			return 4'(c - "a" + 8'd10);
		return 4'(c - "A" + 8'd10);
	endfunction

	function automatic void add_result(input logic [7:0] data, input kind_t k);
		decoded_t r;
		if (byte_results.size() < RES_MAX) begin
			r.data = data;
			r.kind = k;
			r.pn = pairs_closed;
			r.last = 1'b0;
			byte_results.push_back(r);
		end
	endfunction

	function automatic void emit_decoded(input logic [7:0] c);
		int unsigned cap;
		cap = (phase == IN_KEY) ? KEY_MAX_BYTES : VALUE_MAX_BYTES;
		if (tok_cut)
			return;
		// A decoded zero or a full token drops the rest of the token.
		if (c == CH_NUL || tok_len >= cap) begin
			tok_cut = 1'b1;
			return;
		end
		if (phase == IN_KEY)
			add_result(c, KIND_KEY);
		else
			add_result(c, KIND_VALUE);
		tok_len++;
	endfunction

	function automatic void flush_escape();
		if (esc_held != ESC_NONE)
			emit_decoded(CH_PERCENT);
		if (esc_held == ESC_DIGIT)
			emit_decoded(esc_digit);
		esc_held = ESC_NONE;
	endfunction

	function automatic void token_byte(input logic [7:0] c);
		if (esc_held == ESC_PERCENT) begin
			if (is_hex(c)) begin
				esc_digit = c;
				esc_held = ESC_DIGIT;
				return;
			end
			flush_escape();
		end else if (esc_held == ESC_DIGIT) begin
			if (is_hex(c)) begin
				esc_held = ESC_NONE;
				emit_decoded({nibble(esc_digit), nibble(c)});
				return;
			end
			flush_escape();
		end
		if (c == CH_PERCENT)
			esc_held = ESC_PERCENT;
		else if (c == CH_PLUS)
			emit_decoded(CH_SPACE);
		else
			emit_decoded(c);
	endfunction

	function automatic void open_token(input parse_phase_t p);
		phase = p;
		tok_len = 0;
		tok_cut = 1'b0;
		esc_held = ESC_NONE;
	endfunction

	function automatic void close_pair();
		flush_escape();
		add_result(8'd0, KIND_PAIR_END);
		pairs_closed++;
	endfunction

	function automatic void clear_query();
		phase = AT_KEY_START;
		esc_held = ESC_NONE;
		esc_digit = 8'd0;
		tok_len = 0;
		tok_cut = 1'b0;
		pairs_closed = '0;
	endfunction

	function automatic void decode_raw_byte(input logic [7:0] c, input logic last);
		logic [LIMIT_W-1:0] lim;
		decoded_t r;
		lim = (pair_limit < MAX_PAIRS) ? pair_limit : LIMIT_W'(MAX_PAIRS);
		byte_results.delete();
		case (phase)
			AT_KEY_START: begin
				if (c == CH_NUL || c == CH_AMP || c == CH_EQUALS || pairs_closed >= lim)
					phase = STOPPED;
				else begin
					open_token(IN_KEY);
					token_byte(c);
				end
			end
			IN_KEY, IN_VALUE: begin
				if (c == CH_NUL) begin
					close_pair();
					phase = STOPPED;
				end else if (c == CH_AMP) begin
					close_pair();
					phase = AT_KEY_START;
				end else if (c == CH_EQUALS && phase == IN_KEY) begin
					flush_escape();
					open_token(IN_VALUE);
				end else
					token_byte(c);
			end
			default: ;
		endcase
		if (last) begin
			if (phase == IN_KEY || phase == IN_VALUE)
				close_pair();
			add_result(8'd0, KIND_QUERY_END);
			clear_query();
		end
		if (byte_results.size() > 0) begin
			r = byte_results.pop_back();
			r.last = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			decoded_queue.push_back(byte_results[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("checker: result %0d: %s", results_checked, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		if (!arst_n) begin
			pair_limit = LIMIT_RESET;
			clear_query();
			decoded_queue.delete();
		end else begin
			// Results are checked before this edge's input item is predicted.
			if (out_valid && !out_stall) begin
				if (decoded_queue.size() == 0)
					report_mismatch($sformatf("unexpected result, kind %0d byte %02h",
						kind, out_byte));
				else begin
					want = decoded_queue.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
					if (pair_number !== want.pn)
						report_mismatch($sformatf("pair_number %0d, expected %0d",
							pair_number, want.pn));
					if (last_result !== want.last)
						report_mismatch($sformatf("last_result %0b, expected %0b",
							last_result, want.last));
				end
				results_checked++;
			end
			if (cfg_valid && cfg_ready)
				pair_limit = pair_cap;
			if (in_valid && !in_stall)
				decode_raw_byte(data_byte, last_byte);
		end
		outstanding = decoded_queue.size();
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import qspd_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_BYTES = 36;
	localparam int LONG_TOKEN   = 20;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] pair_cap;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         out_byte;
	logic [1:0]         kind;
	logic [PAIR_W-1:0]  pair_number;
	logic               last_result;

	int mismatches;
	int outstanding;
	int results_checked;
	int cycles;
	int bytes_sent;
	int limits_written;
	bit no_gaps;
	bit rx_hold;
	bit hold_request;
	logic [7:0] query_bytes[$];

	query_string_percent_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.pair_cap   (pair_cap),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.pair_number(pair_number),
		.last_result(last_result)
	);

	query_decode_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.pair_cap       (pair_cap),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.kind           (kind),
		.pair_number    (pair_number),
		.last_result    (last_result),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: timeout after %0d cycles", cycles);
		$display("tb: failure");
		$finish;
	end

	// Result side: random stalls after each taken item, or a long hold when requested.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold)
				out_stall <= 1'b1;
			else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall && !no_gaps) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		rx_hold = 1'b0;
		wait (hold_request);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_query();
		foreach (query_bytes[i])
			send_byte(query_bytes[i], i == query_bytes.size() - 1);
	endtask

	// Called at the edge that took the last item; returns once the block has drained.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		pair_cap <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		limits_written++;
	endtask

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			query_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 10)
			return 8'("0" + v);
		return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	function automatic logic [7:0] plain_char();
		case ($urandom_range(0, 2))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			default: return 8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	function automatic void add_token(input int units, input bit in_value);
		logic [7:0] v;
		repeat (units) begin
			case ($urandom_range(0, 15))
				0, 1: query_bytes.push_back(CH_PLUS);
				2, 3, 4: begin
					// Decoded zero shows up now and then to cut the token.
					v = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
					query_bytes.push_back(CH_PERCENT);
					query_bytes.push_back(hex_char(v[7:4], $urandom_range(0, 1)));
					query_bytes.push_back(hex_char(v[3:0], $urandom_range(0, 1)));
				end
				5: begin
					// Broken escape; it may also end right at a delimiter.
					query_bytes.push_back(CH_PERCENT);
					if ($urandom_range(0, 1))
						query_bytes.push_back(hex_char(4'($urandom_range(0, 15)),
							$urandom_range(0, 1)));
					if ($urandom_range(0, 1))
						query_bytes.push_back(8'("g" + $urandom_range(0, 19)));
				end
				6: query_bytes.push_back(in_value ? CH_EQUALS : plain_char());
				default: query_bytes.push_back(plain_char());
			endcase
		end
	endfunction

	function automatic void build_query();
		int pairs;
		query_bytes.delete();
		pairs = $urandom_range(1, 5);
		for (int p = 0; p < pairs; p++) begin
			if (p > 0)
				query_bytes.push_back(CH_AMP);
			add_token($urandom_range(1, 4), 1'b0);
			if ($urandom_range(0, 3) != 0) begin
				query_bytes.push_back(CH_EQUALS);
				add_token($urandom_range(0, 5), 1'b1);
			end
		end
		if ($urandom_range(0, 5) == 0)
			query_bytes.push_back(CH_AMP);
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return CH_NUL;
			1: return CH_AMP;
			2: return CH_EQUALS;
			3: return CH_PERCENT;
			4: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int rand_bytes;
		int sel;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'd0;
		last_byte <= 1'b0;
		cfg_valid <= 1'b0;
		pair_cap <= '0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		bytes_sent = 0;
		limits_written = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plus, escapes, bad escape, '=' in a value, empty key after a pair.
		write_limit(LIMIT_W'(MAX_PAIRS));
		query_bytes.delete();
		push_text("k+=%7e%g=&&");
		send_query();
		// Top byte value, delimiter inside an escape, decoded zero, raw zero.
		query_bytes.delete();
		query_bytes.push_back(8'hFF);
		push_text("a%4&%00q");
		query_bytes.push_back(CH_NUL);
		push_text("y");
		send_query();
		// Last byte breaks a held escape: the most results one item can cause.
		query_bytes.delete();
		push_text("z=%4g");
		send_query();
		settle();
		write_limit('0);
		query_bytes.delete();
		push_text("a");
		send_query();
		settle();
		write_limit(LIMIT_W'(1));
		query_bytes.delete();
		push_text("a&b");
		send_query();
		settle();

		// Long key and value offered back to back while the result side is held.
		write_limit('1);
		query_bytes.delete();
		repeat (LONG_TOKEN) query_bytes.push_back(plain_char());
		query_bytes.push_back(CH_EQUALS);
		repeat (LONG_TOKEN) query_bytes.push_back(plain_char());
		no_gaps = 1'b1;
		hold_request = 1'b1;
		send_query();
		settle();

		rand_bytes = 0;
		while (rand_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: write_limit('0);
					1: write_limit(LIMIT_W'(1));
					2: write_limit(LIMIT_W'(2));
					3: write_limit('1);
					default: write_limit(LIMIT_W'($urandom_range(1, 31)));
				endcase
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (sel < 9) begin
				build_query();
				if (sel >= 7)
					query_bytes.insert($urandom_range(0, query_bytes.size()), noise_byte());
			end else begin
				query_bytes.delete();
				repeat ($urandom_range(1, 8)) query_bytes.push_back(noise_byte());
			end
			rand_bytes += query_bytes.size();
			send_query();
			settle();
		end

		$display("tb: %0d bytes sent, %0d results checked, %0d pair limits written",
			bytes_sent, results_checked, limits_written);
		$display("tb: covered escapes, token cuts, pair limits, stops and a held result side");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
